### rtl/psg_pkg.sv
package psg_pkg;

    localparam int NUM_TONE   = 3;
    localparam int NUM_CH     = 4;
    localparam int NOISE_CH   = 3;
    localparam int PERIOD_W   = 10;
    localparam int NCNT_W     = 11;
    localparam int SHIFT_W    = 16;
    localparam int SAMPLE_W   = 11;
    localparam int VOL_W      = 8;

    localparam logic [2:0]         NOISE_REG    = 3'd6;
    localparam int                 NOISE_WHITE  = 2;
    localparam logic [SHIFT_W-1:0] SHIFT_SEED   = 16'h8000;
    localparam logic [3:0]         ATT_SILENT   = 4'hF;

    typedef logic [PERIOD_W-1:0] period_t;

    // Noise rate select, low two bits of the noise control register
    typedef enum logic [1:0] {
        NRATE_32    = 2'd0,
        NRATE_64    = 2'd1,
        NRATE_128   = 2'd2,
        NRATE_TONE2 = 2'd3
    } nrate_t;

    // One operation applied to the sound state
    typedef struct packed {
        logic       tick;
        logic       write;
        logic [7:0] data;
    } psg_op_t;

    // Register file view handed to the oscillators
    typedef struct packed {
        logic [NUM_TONE-1:0][PERIOD_W-1:0] period;
        logic [2:0]                        noise_ctl;
        logic                              seed;
    } psg_cfg_t;

    function automatic logic [VOL_W-1:0] volume(input logic [3:0] att);
        logic [VOL_W-1:0] v;
        case (att)
            4'd0:    v = 8'd160;
            4'd1:    v = 8'd127;
            4'd2:    v = 8'd101;
            4'd3:    v = 8'd80;
            4'd4:    v = 8'd64;
            4'd5:    v = 8'd51;
            4'd6:    v = 8'd40;
            4'd7:    v = 8'd32;
            4'd8:    v = 8'd25;
            4'd9:    v = 8'd20;
            4'd10:   v = 8'd16;
            4'd11:   v = 8'd13;
            4'd12:   v = 8'd10;
            4'd13:   v = 8'd8;
            4'd14:   v = 8'd6;
            default: v = 8'd0;
        endcase
        return v;
    endfunction

    function automatic logic [NCNT_W-1:0] noise_reload(input logic [1:0] rate,
                                                       input period_t    period2);
        logic [NCNT_W-1:0] r;
        case (nrate_t'(rate))
            NRATE_32:    r = 11'd32;
            NRATE_64:    r = 11'd64;
            NRATE_128:   r = 11'd128;
            NRATE_TONE2: r = (period2 == '0) ? 11'd2 : {period2, 1'b0};
            default:     r = 11'd32;
        endcase
        return r;
    endfunction

endpackage

### rtl/psg_if.sv
interface psg_in_if;
    logic       valid;
    logic       ready;
    logic       func;
    logic [7:0] data_byte;

    modport source (output valid, output func, output data_byte, input ready);
    modport sink   (input valid, input func, input data_byte, output ready);
endinterface

interface psg_out_if;
    logic              valid;
    logic              ready;
    logic signed [10:0] mixed_sample;

    modport source (output valid, output mixed_sample, input ready);
    modport sink   (input valid, input mixed_sample, output ready);
endinterface

### rtl/psg_ctrl.sv
module psg_ctrl (
    input  logic                              clk,
    input  logic                              rst_n,
    input  psg_pkg::psg_op_t                  op,
    output psg_pkg::psg_cfg_t                 cfg,
    output logic [psg_pkg::NUM_CH-1:0][3:0]   att_next
);
    import psg_pkg::*;

    logic [2:0]                        sel_reg, sel_next;
    logic [NUM_TONE-1:0][PERIOD_W-1:0] period_reg, period_next;
    logic [NUM_CH-1:0][3:0]            att_reg;
    logic [2:0]                        noise_ctl_reg, noise_ctl_next;
    logic [2:0]                        r;

    always_comb
    begin
        sel_next       = sel_reg;
        period_next    = period_reg;
        att_next       = att_reg;
        noise_ctl_next = noise_ctl_reg;
        r              = sel_reg;
        if (op.write)
        begin
            if (op.data[7])
            begin
                // latch byte: select and load low bits
                sel_next = op.data[6:4];
                r        = op.data[6:4];
                if (r[0])
                    att_next[r[2:1]] = op.data[3:0];
                else if (r == NOISE_REG)
                    noise_ctl_next = op.data[2:0];
                else
                    period_next[r[2:1]][3:0] = op.data[3:0];
            end
            else
            begin
                if (r[0])
                    att_next[r[2:1]] = op.data[3:0];
                else if (r != NOISE_REG)
                    period_next[r[2:1]][PERIOD_W-1:4] = op.data[5:0];
            end
        end
    end

    assign cfg.period    = period_reg;
    assign cfg.noise_ctl = noise_ctl_reg;
    assign cfg.seed      = op.write && (sel_next == NOISE_REG);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sel_reg       <= '0;
            period_reg    <= '0;
            att_reg       <= {NUM_CH{ATT_SILENT}};
            noise_ctl_reg <= '0;
        end
        else
        begin
            sel_reg       <= sel_next;
            period_reg    <= period_next;
            att_reg       <= att_next;
            noise_ctl_reg <= noise_ctl_next;
        end
    end

endmodule

### rtl/psg_osc.sv
module psg_osc (
    input  logic                         clk,
    input  logic                         rst_n,
    input  psg_pkg::psg_op_t             op,
    input  psg_pkg::psg_cfg_t            cfg,
    output logic [psg_pkg::NUM_CH-1:0]   sign_next
);
    import psg_pkg::*;

    logic [NUM_TONE-1:0][PERIOD_W-1:0] tone_cnt_reg, tone_cnt_next;
    logic [NCNT_W-1:0]                 noise_cnt_reg, noise_cnt_next;
    logic [NUM_CH-1:0]                 sign_reg;
    logic [SHIFT_W-1:0]                shift_reg, shift_next;
    logic                              fb;

    always_comb
    begin
        tone_cnt_next  = tone_cnt_reg;
        noise_cnt_next = noise_cnt_reg;
        sign_next      = sign_reg;
        shift_next     = shift_reg;
        fb             = 1'b0;
        if (op.tick)
        begin
            for (int i = 0; i < NUM_TONE; i++)
            begin
                if (tone_cnt_reg[i] <= PERIOD_W'(1))
                begin
                    // expire: reload, zero period counts as one, flip sign
                    tone_cnt_next[i] = (cfg.period[i] == '0) ? PERIOD_W'(1) : cfg.period[i];
                    sign_next[i]     = ~sign_reg[i];
                end
                else
                    tone_cnt_next[i] = tone_cnt_reg[i] - PERIOD_W'(1);
            end
            if (noise_cnt_reg <= NCNT_W'(1))
            begin
                noise_cnt_next = noise_reload(cfg.noise_ctl[1:0], cfg.period[NUM_TONE-1]);
                fb = cfg.noise_ctl[NOISE_WHITE] ? (shift_reg[0] ^ shift_reg[3]) : shift_reg[0];
                shift_next = {fb, shift_reg[SHIFT_W-1:1]};
                sign_next[NOISE_CH] = ~shift_next[0];
            end
            else
                noise_cnt_next = noise_cnt_reg - NCNT_W'(1);
        end
        else if (cfg.seed)
            shift_next = SHIFT_SEED;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tone_cnt_reg  <= '0;
            noise_cnt_reg <= '0;
            sign_reg      <= '0;
            shift_reg     <= SHIFT_SEED;
        end
        else
        begin
            tone_cnt_reg  <= tone_cnt_next;
            noise_cnt_reg <= noise_cnt_next;
            sign_reg      <= sign_next;
            shift_reg     <= shift_next;
        end
    end

`ifndef SYNTHESIS
    a_shift_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        shift_reg != '0)
        else $error("noise shift register reached zero");

    a_noise_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
        noise_cnt_reg <= NCNT_W'(2046))
        else $error("noise counter above largest reload");

    a_tone_cnt_loaded: assert property (@(posedge clk) disable iff (!rst_n)
        op.tick |=> (tone_cnt_reg[0] != '0) && (tone_cnt_reg[1] != '0)
                    && (tone_cnt_reg[2] != '0))
        else $error("tone counter zero after tick");
`endif

endmodule

### rtl/psg_mix.sv
module psg_mix (
    input  logic [psg_pkg::NUM_CH-1:0][3:0]      att,
    input  logic [psg_pkg::NUM_CH-1:0]           sign,
    output logic signed [psg_pkg::SAMPLE_W-1:0]  sample
);
    import psg_pkg::*;

    logic signed [SAMPLE_W-1:0] term [NUM_CH];

    always_comb
    begin
        sample = '0;
        for (int i = 0; i < NUM_CH; i++)
        begin
            term[i] = $signed({{(SAMPLE_W-VOL_W){1'b0}}, volume(att[i])});
            // sign set means negative half of the wave
            sample  = sign[i] ? (sample - term[i]) : (sample + term[i]);
        end
    end

endmodule

### rtl/psg_tone_noise_generator.sv
// Sound generator: three square tone channels and one noise channel mixed
// into one signed 11-bit sample.
// Input channel req carries func (0 = register byte write, 1 = one tick)
// and data_byte; output channel rsp returns mixed_sample, one result per
// transfer on req, in order.
// A transfer accepted on req passes through the input register, then the
// state update and mix into the result register, and its result is then
// shown on rsp. Throughput: one item per clock; req.ready stays high as long
// as the result register is empty or taken in the same cycle.
// Reset (rst_n low, asynchronous) silences all channels, clears periods,
// counters and noise control, selects register 0 and seeds the noise
// shift register with 0x8000. Both pipeline stages come out empty.
// When the receiver stalls, the result stays on rsp, one more item waits in
// the input register, and req.ready drops until rsp is taken.
module psg_tone_noise_generator (
    input  logic      clk,
    input  logic      rst_n,
    psg_in_if.sink    req,
    psg_out_if.source rsp
);
    import psg_pkg::*;

    logic                       s1_valid_reg;
    logic                       s1_func_reg;
    logic [7:0]                 s1_data_reg;
    logic                       out_valid_reg;
    logic signed [SAMPLE_W-1:0] sample_reg;

    logic                       advance;
    logic                       apply;
    psg_op_t                    op;
    psg_cfg_t                   cfg;
    logic [NUM_CH-1:0][3:0]     att_next;
    logic [NUM_CH-1:0]          sign_next;
    logic signed [SAMPLE_W-1:0] mix_sample;

    // Move stage 1 on when the result register is free or being drained
    assign advance   = !out_valid_reg || rsp.ready;
    assign apply     = s1_valid_reg && advance;
    assign req.ready = !s1_valid_reg || advance;

    assign op.tick  = apply && s1_func_reg;
    assign op.write = apply && !s1_func_reg;
    assign op.data  = s1_data_reg;

    psg_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .op       (op),
        .cfg      (cfg),
        .att_next (att_next)
    );

    psg_osc u_osc (
        .clk       (clk),
        .rst_n     (rst_n),
        .op        (op),
        .cfg       (cfg),
        .sign_next (sign_next)
    );

    // Mix the state as it stands after this item's update
    psg_mix u_mix (
        .att    (att_next),
        .sign   (sign_next),
        .sample (mix_sample)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (req.valid && req.ready)
                s1_valid_reg <= 1'b1;
            else if (advance)
                s1_valid_reg <= 1'b0;
            if (advance)
                out_valid_reg <= s1_valid_reg;
        end
    end

    // Payload: hold unless a new transfer lands
    always_ff @(posedge clk)
    begin
        if (req.valid && req.ready)
        begin
            s1_func_reg <= req.func;
            s1_data_reg <= req.data_byte;
        end
        if (apply)
            sample_reg <= mix_sample;
    end

    assign rsp.valid        = out_valid_reg;
    assign rsp.mixed_sample = sample_reg;

`ifndef SYNTHESIS
    a_apply_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
        apply |=> rsp.valid)
        else $error("applied item produced no result");

    a_sample_range: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid |-> (rsp.mixed_sample >= -11'sd640) && (rsp.mixed_sample <= 11'sd640))
        else $error("mixed sample out of range");

    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !rsp.valid |-> req.ready)
        else $error("input stalled with empty result register");
`endif

endmodule
